>>> hw/rtl/amx_pkg.sv
package amx_pkg;

    localparam int MEM_WORDS_DEF = 128;
    localparam int PC_W          = 7;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 4;

    localparam logic [OP_W-1:0] OP_READ       = 4'd0;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd2;
    localparam logic [OP_W-1:0] OP_STORE      = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD        = 4'd4;
    localparam logic [OP_W-1:0] OP_SUB        = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL        = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV        = 4'd7;
    localparam logic [OP_W-1:0] OP_BRANCH     = 4'd8;
    localparam logic [OP_W-1:0] OP_BRANCHNEG  = 4'd9;
    localparam logic [OP_W-1:0] OP_BRANCHZERO = 4'd10;
    localparam logic [OP_W-1:0] OP_HALT       = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [PC_W-1:0]          addr;
        logic signed [WORD_W-1:0] in_value;
    } amx_in_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic signed [WORD_W-1:0] acc_value;
        logic signed [WORD_W-1:0] out_value;
        logic                     out_valid;
        logic                     halted;
        logic                     div_zero;
    } amx_out_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [PC_W-1:0]   addr;
        logic [WORD_W-1:0] wdata;
    } amx_mem_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              sub;
    } amx_alu_req_t;

endpackage

>>> hw/rtl/amx_in_if.sv
interface amx_in_if;
    import amx_pkg::*;

    logic    valid;
    logic    ready;
    amx_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/amx_out_if.sv
interface amx_out_if;
    import amx_pkg::*;

    logic     valid;
    logic     ready;
    amx_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/amx_alu.sv
module amx_alu (
    input  amx_pkg::amx_alu_req_t req,
    output logic [amx_pkg::WORD_W:0] sum
);
    import amx_pkg::*;

    logic [WORD_W-1:0] b_eff;

    // The top bit is the carry out; on a subtract it is set when a >= b.
    assign b_eff = req.sub ? ~req.b : req.b;
    assign sum   = {1'b0, req.a} + {1'b0, b_eff} + (WORD_W+1)'(req.sub);
endmodule

>>> hw/rtl/amx_mem.sv
module amx_mem #(
    parameter int MEM_WORDS = amx_pkg::MEM_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  amx_pkg::amx_mem_req_t       req,
    output logic [amx_pkg::WORD_W-1:0]  rdata,
    output logic                        busy
);
    import amx_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int IW = (AW > PC_W) ? AW : PC_W;

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [AW-1:0]     idx;

    // Address modulo the memory size. The loop makes at most eight
    // subtractions, enough for any 7-bit address when MEM_WORDS is 15 or more.
    function automatic logic [AW-1:0] word_index(input logic [PC_W-1:0] a);
        logic [IW-1:0] r;
        r = IW'(a);
        for (int k = 0; k < 8; k++)
        begin
            if (32'(r) >= 32'(MEM_WORDS))
            begin
                r = r - IW'(MEM_WORDS);
            end
        end
        return r[AW-1:0];
    endfunction

    assign idx  = word_index(req.addr);
    assign busy = clr_busy_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(MEM_WORDS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata <= mem[idx];
        end
    end
endmodule

>>> hw/rtl/amx_seq.sv
module amx_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  amx_pkg::amx_in_t            in_data,
    output logic                        res_done,
    output amx_pkg::amx_out_t           res_data,
    input  logic                        res_take,
    output amx_pkg::amx_mem_req_t       mem_req,
    input  logic [amx_pkg::WORD_W-1:0]  mem_rdata,
    input  logic                        mem_busy,
    output amx_pkg::amx_alu_req_t       alu_req,
    input  logic [amx_pkg::WORD_W:0]    alu_sum
);
    import amx_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DABS  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DNEG  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [4:0] ITER_LAST = 5'd31;

    logic [2:0]        state_reg,  state_next;
    logic [WORD_W-1:0] acc_reg,    acc_next;
    logic [PC_W-1:0]   pc_reg,     pc_next;
    logic              run_reg,    run_next;
    logic [OP_W-1:0]   op_reg,     op_next;
    logic [PC_W-1:0]   addr_reg,   addr_next;
    logic [WORD_W-1:0] val_reg,    val_next;
    logic [WORD_W-1:0] wa_reg,     wa_next;
    logic [WORD_W-1:0] wb_reg,     wb_next;
    logic [WORD_W-1:0] wc_reg,     wc_next;
    logic [4:0]        cnt_reg,    cnt_next;
    logic              neg_reg,    neg_next;
    logic [WORD_W-1:0] outv_reg,   outv_next;
    logic              outvld_reg, outvld_next;
    logic              dz_reg,     dz_next;
    logic [WORD_W-1:0] rem_shift;

    assign in_ready = (state_reg == S_IDLE);
    assign res_done = (state_reg == S_DONE);
    assign rem_shift = {wc_reg[WORD_W-2:0], wb_reg[WORD_W-1]};

    assign res_data = '{next_pc:   pc_reg,
                        acc_value: acc_reg,
                        out_value: outv_reg,
                        out_valid: outvld_reg,
                        halted:    !run_reg,
                        div_zero:  dz_reg};

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        pc_next     = pc_reg;
        run_next    = run_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        val_next    = val_reg;
        wa_next     = wa_reg;
        wb_next     = wb_reg;
        wc_next     = wc_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        outv_next   = outv_reg;
        outvld_next = outvld_reg;
        dz_next     = dz_reg;
        mem_req     = '{rd: 1'b0, wr: 1'b0, addr: addr_reg, wdata: val_reg};
        alu_req     = '{a: acc_reg, b: mem_rdata, sub: 1'b0};

        unique case (state_reg)
            S_CLEAR:
            begin
                if (!mem_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // The operand read goes out every idle cycle so the word is
                // ready in the execute cycle.
                mem_req.rd   = 1'b1;
                mem_req.addr = in_data.addr;
                if (in_valid)
                begin
                    op_next     = in_data.op;
                    addr_next   = in_data.addr;
                    val_next    = in_data.in_value;
                    outv_next   = '0;
                    outvld_next = 1'b0;
                    dz_next     = 1'b0;
                    state_next  = run_reg ? S_EXEC : S_DONE;
                end
            end
            S_EXEC:
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = S_DONE;
                unique case (op_reg)
                    OP_READ:
                    begin
                        mem_req.wr = 1'b1;
                    end
                    OP_WRITE:
                    begin
                        outv_next   = mem_rdata;
                        outvld_next = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        acc_next = mem_rdata;
                    end
                    OP_STORE:
                    begin
                        mem_req.wr    = 1'b1;
                        mem_req.wdata = acc_reg;
                    end
                    OP_ADD:
                    begin
                        acc_next = alu_sum[WORD_W-1:0];
                    end
                    OP_SUB:
                    begin
                        alu_req.sub = 1'b1;
                        acc_next    = alu_sum[WORD_W-1:0];
                    end
                    OP_MUL:
                    begin
                        wa_next    = acc_reg;
                        wb_next    = mem_rdata;
                        wc_next    = '0;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    OP_DIV:
                    begin
                        if (mem_rdata == '0)
                        begin
                            dz_next  = 1'b1;
                            run_next = 1'b0;
                            pc_next  = pc_reg;
                        end
                        else
                        begin
                            // Divisor magnitude now, dividend magnitude next.
                            alu_req    = '{a: '0, b: mem_rdata, sub: 1'b1};
                            wa_next    = mem_rdata[WORD_W-1] ? alu_sum[WORD_W-1:0]
                                                             : mem_rdata;
                            neg_next   = acc_reg[WORD_W-1] ^ mem_rdata[WORD_W-1];
                            state_next = S_DABS;
                        end
                    end
                    OP_BRANCH:
                    begin
                        pc_next = addr_reg;
                    end
                    OP_BRANCHNEG:
                    begin
                        if (acc_reg[WORD_W-1])
                        begin
                            pc_next = addr_reg;
                        end
                    end
                    OP_BRANCHZERO:
                    begin
                        if (acc_reg == '0)
                        begin
                            pc_next = addr_reg;
                        end
                    end
                    OP_HALT:
                    begin
                        run_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MUL:
            begin
                // Shift-and-add, low word only.
                alu_req  = '{a: wc_reg, b: wa_reg, sub: 1'b0};
                wa_next  = wa_reg << 1;
                wb_next  = wb_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (wb_reg[0])
                begin
                    wc_next = alu_sum[WORD_W-1:0];
                end
                if (cnt_reg == ITER_LAST)
                begin
                    acc_next   = wb_reg[0] ? alu_sum[WORD_W-1:0] : wc_reg;
                    state_next = S_DONE;
                end
            end
            S_DABS:
            begin
                alu_req    = '{a: '0, b: acc_reg, sub: 1'b1};
                wb_next    = acc_reg[WORD_W-1] ? alu_sum[WORD_W-1:0] : acc_reg;
                wc_next    = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring division; the carry out says the trial fits.
                alu_req  = '{a: rem_shift, b: wa_reg, sub: 1'b1};
                cnt_next = cnt_reg + 1'b1;
                if (alu_sum[WORD_W])
                begin
                    wc_next = alu_sum[WORD_W-1:0];
                    wb_next = {wb_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    wc_next = rem_shift;
                    wb_next = {wb_reg[WORD_W-2:0], 1'b0};
                end
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = S_DNEG;
                end
            end
            S_DNEG:
            begin
                alu_req    = '{a: '0, b: wb_reg, sub: 1'b1};
                acc_next   = neg_reg ? alu_sum[WORD_W-1:0] : wb_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            acc_reg    <= '0;
            pc_reg     <= '0;
            run_reg    <= 1'b1;
            outvld_reg <= 1'b0;
            dz_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            pc_reg     <= pc_next;
            run_reg    <= run_next;
            outvld_reg <= outvld_next;
            dz_reg     <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        addr_reg <= addr_next;
        val_reg  <= val_next;
        wa_reg   <= wa_next;
        wb_reg   <= wb_next;
        wc_reg   <= wc_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        outv_reg <= outv_next;
    end
endmodule

>>> hw/rtl/accumulator_machine_execute_unit.sv
// Execute unit of a small accumulator machine: each beat on instr is one
// decoded instruction, and each produces exactly one beat on result with the
// program counter, accumulator, any WRITE word and the halt and divide-by-zero
// flags. After reset the word memory is cleared one word per cycle, and instr
// is not ready until the clear has finished. One instruction is worked at a
// time: the result of an instruction becomes valid and instr becomes ready in
// the same cycle. MUL and DIV take longer than plain instructions, since a
// single 33-bit adder is reused by the sequencer for one multiplier or quotient
// bit per cycle. instr is ready again as soon as the result sits in the output
// register, even if the sink has not taken it yet.
module accumulator_machine_execute_unit #(
    parameter int MEM_WORDS = amx_pkg::MEM_WORDS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    amx_in_if.sink   instr,
    amx_out_if.source result
);
    import amx_pkg::*;

    logic          in_ready;
    logic          res_done;
    logic          res_take;
    amx_out_t      res_data;
    amx_mem_req_t  mem_req;
    logic [WORD_W-1:0] mem_rdata;
    logic          mem_busy;
    amx_alu_req_t  alu_req;
    logic [WORD_W:0] alu_sum;
    logic          out_valid_reg;
    amx_out_t      out_data_reg;

    assign instr.ready  = in_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
    assign res_take     = !out_valid_reg || result.ready;

    amx_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr.valid),
        .in_ready  (in_ready),
        .in_data   (instr.data),
        .res_done  (res_done),
        .res_data  (res_data),
        .res_take  (res_take),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .mem_busy  (mem_busy),
        .alu_req   (alu_req),
        .alu_sum   (alu_sum)
    );

    amx_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    amx_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_done && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done && res_take)
        begin
            out_data_reg <= res_data;
        end
    end
endmodule

>>> hw/rtl/amx_chk.sv
module amx_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input amx_pkg::amx_out_t out_data
);
    import amx_pkg::*;

    logic halt_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && out_data.halted)
        begin
            halt_seen_reg <= 1'b1;
        end
    end

    // A pending result beat must not be withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    // Only one instruction is worked at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("instr ready right after an accepted beat");

    // Once stopped, the machine stays stopped.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halt_seen_reg |-> out_data.halted)
        else $error("machine restarted after a halt");

    a_divzero_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_zero |-> out_data.halted && !out_data.out_valid)
        else $error("divide by zero without halt");

    a_write_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_valid |-> !out_data.halted)
        else $error("WRITE word reported by a stopped machine");
endmodule

bind accumulator_machine_execute_unit amx_chk u_amx_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (instr.valid),
    .in_ready  (instr.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
